// ----- design/pgp_pkg.sv -----
// pgp_pkg: shared constants, register codes and root table for the periodic gaussian unit
`timescale 1ns / 1ps
package pgp_pkg;

   localparam int FULL_TURN_Q8 = 92160;
   localparam int HALF_TURN_Q8 = 46080;
   localparam int LOG2E_Q16    = 94548;
   localparam int X_CAP_Q16    = 2097152;
   localparam int X_QBITS      = 22;
   localparam int S_QBITS      = 32;
   localparam int EXP_STEPS    = 16;

   localparam logic [31:0] AMPLITUDE_RESET = 32'd655360;
   localparam logic [16:0] CENTER_RESET    = 17'd15360;
   localparam logic [15:0] SIGMA_RESET     = 16'd6400;

   typedef enum logic [1:0] {
      CSR_AMPLITUDE = 2'd0,
      CSR_CENTER    = 2'd1,
      CSR_SIGMA     = 2'd2
   } csr_index_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem   = v;
      res   = '0;
      bit_v = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 64'd0) begin
            if (rem >= res + bit_v) begin
               rem = rem - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // 2^(-2^-k) in q30, each entry the square root of the one before
   function automatic logic [63:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'h1 << 29;
      for (int j = 1; j <= EXP_STEPS; j++) begin
         if (j <= k) begin
            r = isqrt64(r << 30);
         end
      end
      return r;
   endfunction

endpackage

// ----- design/periodic_gaussian_potential_unit.sv -----
// periodic_gaussian_potential_unit: pipelined gaussian potential and slope of a dihedral angle
`timescale 1ns / 1ps
// Takes one angle beat on every cycle (busy stays low) and returns potential, slope and the
// saturated flag on a single-cycle rsp_strobe; the receiver cannot stall, so results must be
// taken when shown. The pipeline holds two restoring dividers of one quotient bit per stage
// (22 bits for the exponent argument, 32 for the slope), the sixteen root multiply stages of
// the exp approximation and the shift, multiply and sign stages between. The user must write
// registers through the csr port only while no beat is in flight; the block does not check it.
module periodic_gaussian_potential_unit
   import pgp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [16:0] req_angle,
   output logic        rsp_strobe,
   output logic [31:0] rsp_potential,
   output logic [31:0] rsp_slope,
   output logic        rsp_saturated,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int Latency = 82;
   localparam logic signed [17:0] HalfPos = 18'(HALF_TURN_Q8);
   localparam logic signed [17:0] HalfNeg = -18'(HALF_TURN_Q8);
   localparam logic signed [17:0] FullTurn = 18'(FULL_TURN_Q8);
   localparam logic [21:0] XCap = 22'(X_CAP_Q16);

   // configuration
   logic [31:0] amplitude_ff;
   logic [16:0] center_ff;
   logic [15:0] sigma_ff;
   logic [31:0] sigma_sq_ff;
   logic [15:0] sigma_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff <= AMPLITUDE_RESET;
         center_ff    <= CENTER_RESET;
         sigma_ff     <= SIGMA_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_AMPLITUDE: amplitude_ff <= csr_write_data;
            CSR_CENTER:    center_ff    <= csr_write_data[16:0];
            CSR_SIGMA:     sigma_ff     <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign sigma_eff = (sigma_ff == 16'd0) ? 16'd1 : sigma_ff;

   always_ff @(posedge clock) begin
      sigma_sq_ff <= sigma_eff * sigma_eff;
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // stage: raw distance
   logic              v0_ff;
   logic signed [17:0] draw_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= accept;
   end
   always_ff @(posedge clock) begin
      draw_ff <= $signed({req_angle[16], req_angle}) - $signed({center_ff[16], center_ff});
   end

   // stage: nearest periodic image
   logic              v1_ff;
   logic signed [17:0] d1_ff;
   logic signed [17:0] d1_in;
   always_comb begin
      if (draw_ff < HalfNeg)      d1_in = draw_ff + FullTurn;
      else if (draw_ff > HalfPos) d1_in = draw_ff - FullTurn;
      else                        d1_in = draw_ff;
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      d1_ff <= d1_in;
   end

   // stage: square of distance
   logic              v2_ff;
   logic signed [17:0] d2_ff;
   logic [31:0]        dsq_ff;
   logic signed [35:0] dsq_full;
   assign dsq_full = d1_ff * d1_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      d2_ff  <= d1_ff;
      dsq_ff <= dsq_full[31:0];
   end

   // divider for x = d^2 * 2^16 / (2 s^2), one quotient bit a stage
   logic [32:0] den1;
   assign den1 = {sigma_sq_ff, 1'b0};

   logic               xv_ff [0:X_QBITS];
   logic [47:0]        xr_ff [0:X_QBITS];
   logic [21:0]        xq_ff [0:X_QBITS];
   logic               xc_ff [0:X_QBITS];
   logic signed [17:0] xd_ff [0:X_QBITS];

   always_ff @(posedge clock) begin
      if (reset) xv_ff[0] <= 1'b0;
      else       xv_ff[0] <= v2_ff;
      xr_ff[0] <= {dsq_ff, 16'd0};
      xq_ff[0] <= '0;
      xc_ff[0] <= {8'd0, dsq_ff, 16'd0} >= {1'b0, den1, 22'd0};
      xd_ff[0] <= d2_ff;
   end

   for (genvar j = 1; j <= X_QBITS; j++) begin : g_xdiv
      localparam int Bit = X_QBITS - j;
      logic [55:0] dsh;
      logic        take;
      assign dsh  = {23'd0, den1} << Bit;
      assign take = {8'd0, xr_ff[j-1]} >= dsh;
      always_ff @(posedge clock) begin
         if (reset) xv_ff[j] <= 1'b0;
         else       xv_ff[j] <= xv_ff[j-1];
         xc_ff[j] <= xc_ff[j-1];
         xd_ff[j] <= xd_ff[j-1];
         if (take) begin
            xr_ff[j] <= xr_ff[j-1] - dsh[47:0];
            xq_ff[j] <= xq_ff[j-1] | (22'd1 << Bit);
         end else begin
            xr_ff[j] <= xr_ff[j-1];
            xq_ff[j] <= xq_ff[j-1];
         end
      end
   end

   // stage: cap x, y = x * log2(e) rounded, split into integer and fraction
   logic [21:0] x_cap;
   logic [38:0] y_sum;
   assign x_cap = (xc_ff[X_QBITS] || xq_ff[X_QBITS] > XCap) ? XCap : xq_ff[X_QBITS];
   assign y_sum = ({17'd0, x_cap} * 39'(LOG2E_Q16)) + 39'd32768;

   logic               gv_ff [0:EXP_STEPS];
   logic [30:0]        gg_ff [0:EXP_STEPS];
   logic [15:0]        gf_ff [0:EXP_STEPS];
   logic [5:0]         gn_ff [0:EXP_STEPS];
   logic signed [17:0] gd_ff [0:EXP_STEPS];

   always_ff @(posedge clock) begin
      if (reset) gv_ff[0] <= 1'b0;
      else       gv_ff[0] <= xv_ff[X_QBITS];
      gg_ff[0] <= 31'h4000_0000;
      gf_ff[0] <= y_sum[31:16];
      gn_ff[0] <= y_sum[37:32];
      gd_ff[0] <= xd_ff[X_QBITS];
   end

   // 2^-f as a product of roots, one multiply a stage
   for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
      localparam logic [30:0] Root = 31'(root_q30(k));
      logic [61:0] prod;
      assign prod = ({31'd0, gg_ff[k-1]} * {31'd0, Root}) + 62'h2000_0000;
      always_ff @(posedge clock) begin
         if (reset) gv_ff[k] <= 1'b0;
         else       gv_ff[k] <= gv_ff[k-1];
         gf_ff[k] <= gf_ff[k-1];
         gn_ff[k] <= gn_ff[k-1];
         gd_ff[k] <= gd_ff[k-1];
         if (gf_ff[k-1][EXP_STEPS-k]) gg_ff[k] <= prod[60:30];
         else                         gg_ff[k] <= gg_ff[k-1];
      end
   end

   // stage: 2^-n
   logic               sv_ff;
   logic [30:0]        gs_ff;
   logic signed [17:0] sd_ff;
   always_ff @(posedge clock) begin
      if (reset) sv_ff <= 1'b0;
      else       sv_ff <= gv_ff[EXP_STEPS];
      gs_ff <= gg_ff[EXP_STEPS] >> gn_ff[EXP_STEPS];
      sd_ff <= gd_ff[EXP_STEPS];
   end

   // stage: potential = amplitude * g, rounded (never leaves the 32-bit range)
   logic               pv_ff;
   logic [31:0]        pot_ff;
   logic signed [17:0] pd_ff;
   logic signed [63:0] pot_sum;
   assign pot_sum = ($signed(amplitude_ff) * $signed({1'b0, gs_ff})) + 64'sh2000_0000;
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else       pv_ff <= sv_ff;
      pot_ff <= pot_sum[61:30];
      pd_ff  <= sd_ff;
   end

   // stage: potential * d
   logic               nv_ff;
   logic [31:0]        npot_ff;
   logic signed [49:0] np_ff;
   always_ff @(posedge clock) begin
      if (reset) nv_ff <= 1'b0;
      else       nv_ff <= pv_ff;
      npot_ff <= pot_ff;
      np_ff   <= $signed(pot_ff) * pd_ff;
   end

   // stage: magnitude and sign
   logic        av_ff;
   logic [31:0] apot_ff;
   logic [49:0] amag_ff;
   logic        aneg_ff;
   always_ff @(posedge clock) begin
      if (reset) av_ff <= 1'b0;
      else       av_ff <= nv_ff;
      apot_ff <= npot_ff;
      aneg_ff <= np_ff[49];
      amag_ff <= np_ff[49] ? 50'(-np_ff) : 50'(np_ff);
   end

   // stage: scale by 256 and add half the divisor for rounding
   logic        bv_ff;
   logic [31:0] bpot_ff;
   logic        bneg_ff;
   logic [57:0] bnum_ff;
   always_ff @(posedge clock) begin
      if (reset) bv_ff <= 1'b0;
      else       bv_ff <= av_ff;
      bpot_ff <= apot_ff;
      bneg_ff <= aneg_ff;
      bnum_ff <= {amag_ff, 8'd0} + {27'd0, sigma_sq_ff[31:1]};
   end

   // divider for slope magnitude by s^2, one quotient bit a stage
   logic        qv_ff   [0:S_QBITS];
   logic [57:0] qr_ff   [0:S_QBITS];
   logic [31:0] qq_ff   [0:S_QBITS];
   logic        qbig_ff [0:S_QBITS];
   logic        qneg_ff [0:S_QBITS];
   logic [31:0] qpot_ff [0:S_QBITS];

   always_ff @(posedge clock) begin
      if (reset) qv_ff[0] <= 1'b0;
      else       qv_ff[0] <= bv_ff;
      qr_ff[0]   <= bnum_ff;
      qq_ff[0]   <= '0;
      qbig_ff[0] <= {6'd0, bnum_ff} >= {sigma_sq_ff, 32'd0};
      qneg_ff[0] <= bneg_ff;
      qpot_ff[0] <= bpot_ff;
   end

   for (genvar j = 1; j <= S_QBITS; j++) begin : g_sdiv
      localparam int Bit = S_QBITS - j;
      logic [63:0] dsh;
      logic        take;
      assign dsh  = {32'd0, sigma_sq_ff} << Bit;
      assign take = {6'd0, qr_ff[j-1]} >= dsh;
      always_ff @(posedge clock) begin
         if (reset) qv_ff[j] <= 1'b0;
         else       qv_ff[j] <= qv_ff[j-1];
         qbig_ff[j] <= qbig_ff[j-1];
         qneg_ff[j] <= qneg_ff[j-1];
         qpot_ff[j] <= qpot_ff[j-1];
         if (take) begin
            qr_ff[j] <= qr_ff[j-1] - dsh[57:0];
            qq_ff[j] <= qq_ff[j-1] | (32'd1 << Bit);
         end else begin
            qr_ff[j] <= qr_ff[j-1];
            qq_ff[j] <= qq_ff[j-1];
         end
      end
   end

   // output stage: sign and clamp
   logic [31:0] q_fin;
   logic [31:0] slope_in;
   logic        sat_in;
   assign q_fin = qq_ff[S_QBITS];
   always_comb begin
      if (qneg_ff[S_QBITS]) begin
         if (qbig_ff[S_QBITS] || q_fin > 32'h8000_0000) begin
            slope_in = 32'h8000_0000;
            sat_in   = 1'b1;
         end else begin
            slope_in = 32'(-q_fin);
            sat_in   = 1'b0;
         end
      end else begin
         if (qbig_ff[S_QBITS] || q_fin > 32'h7fff_ffff) begin
            slope_in = 32'h7fff_ffff;
            sat_in   = 1'b1;
         end else begin
            slope_in = q_fin;
            sat_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= qv_ff[S_QBITS];
      rsp_potential <= qpot_ff[S_QBITS];
      rsp_slope     <= slope_in;
      rsp_saturated <= sat_in;
   end

   // every result beat comes from a request beat a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, Latency))
      else $error("result beat without matching request beat");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_slope == 32'h7fff_ffff || rsp_slope == 32'h8000_0000))
      else $error("saturated flag without clamped slope");

   a_zero_pot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_potential == 32'd0) |-> (rsp_slope == 32'd0 && !rsp_saturated))
      else $error("nonzero slope with zero potential");

endmodule
